// ----- rtl/ammc_pkg.sv -----
// Shared types, constants and helper functions of the air mouse motion conditioner.
package ammc_pkg;

  // Field widths
  localparam int LEVEL_W    = 3;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 8;
  localparam int DZ_W       = 15;
  localparam int SAMPLE_W   = 16;
  localparam int STICK_W    = 12;
  localparam int MOVE_W     = 8;
  localparam int SCROLL_W   = 4;
  localparam int FILT_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Default number of sensitivity levels
  localparam int LEVELS_DEF = 5;
  localparam logic [LEVEL_W-1:0] LEVEL_RST = 3'd3;

  // Register reset values
  localparam logic [DEB_W-1:0] DEBOUNCE_RST  = 8'd10;
  localparam logic [DZ_W-1:0]  YAW_DZ_RST    = 15'd30;
  localparam logic [DZ_W-1:0]  ACCEL_DZ_RST  = 15'd600;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_YAW_DZ   = 2'd1,
    CFG_ACCEL_DZ = 2'd2
  } cfg_idx_e;

  // Button slots
  localparam int NUM_BTN    = 4;
  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_ENABLE = 2;
  localparam int BTN_MODE   = 3;

  // Scaling divisors
  localparam int YAW_DIV   = 5;
  localparam int ACCEL_DIV = 175;

  // Low-pass filter weights in Q8: X keeps half, Y takes 154/256 of the new value
  localparam int FILT_X_IN_SH   = 7;
  localparam int FILT_X_KEEP_SH = 1;
  localparam int FILT_Y_IN      = 154;
  localparam int FILT_Y_KEEP    = 102;
  localparam int Q_SH           = 8;

  localparam int MOVE_LIM = 127;

  // Joystick scroll mapping
  localparam int SCROLL_LOW   = 1830;
  localparam int SCROLL_HIGH  = 1850;
  localparam int STICK_MAX    = 4095;
  localparam int SCROLL_STEPS = 5;

  // Information that travels with one tick through the pipeline
  typedef struct packed {
    logic                       normal;
    logic                       en_held;
    logic                       click_l;
    logic                       click_r;
    logic                       scroll_v;
    logic signed [SCROLL_W-1:0] scroll;
    logic                       tuning;
    logic [LEVEL_W-1:0]         level;
  } tick_info_t;

  // Wheel steps for a joystick reading; readings giving fewer than two steps map to zero.
  // Each threshold is the smallest reading at which the truncated quotient reaches k.
  function automatic logic signed [SCROLL_W-1:0] scroll_of(input logic [STICK_W-1:0] stick);
    int lo_cnt;
    int hi_cnt;
    int s;
    lo_cnt = 0;
    hi_cnt = 0;
    for (int k = 1; k < SCROLL_STEPS; k++) begin
      if (int'(stick) >= (SCROLL_LOW * k + SCROLL_STEPS - 1) / SCROLL_STEPS) begin
        lo_cnt = lo_cnt + 1;
      end
    end
    for (int k = 1; k <= SCROLL_STEPS; k++) begin
      if (int'(stick) >= SCROLL_HIGH +
          ((STICK_MAX - SCROLL_HIGH) * k + SCROLL_STEPS - 1) / SCROLL_STEPS) begin
        hi_cnt = hi_cnt + 1;
      end
    end
    if (int'(stick) < SCROLL_LOW) begin
      s = SCROLL_STEPS - lo_cnt;
    end else begin
      s = -hi_cnt;
    end
    if (s > 1 || s < -1) begin
      return SCROLL_W'(s);
    end
    return '0;
  endfunction

endpackage

// ----- rtl/air_mouse_motion_conditioner_top.sv -----
// Air mouse motion conditioner: debounce, tuning mode, motion scaling and filtering, scroll.
//
// One polling tick is accepted per clock cycle while the pipeline is not held; its result
// passes through each stage in turn. The pipeline has an input register,
// a stage that debounces the buttons, updates the mode, level and previous accel sample
// and multiplies by the gain, a stage that divides by 5 and 175 through reciprocal
// multipliers, and a stage holding the low-pass filters, which feeds the result register.
// The whole pipeline holds while a result waits to be taken, so in_ready_o falls only
// then. Configuration registers are read by the debounce and dead-zone logic and must be
// written while no tick is in flight.
module air_mouse_motion_conditioner_top
  import ammc_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  // Tick input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         link_up_i,
  input  logic [TIME_W-1:0]            now_ms_i,
  input  logic                         left_level_i,
  input  logic                         right_level_i,
  input  logic                         enable_level_i,
  input  logic                         mode_level_i,
  input  logic signed [SAMPLE_W-1:0]   accel_x_i,
  input  logic signed [SAMPLE_W-1:0]   yaw_step_i,
  input  logic [STICK_W-1:0]           stick_y_i,
  // Result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         move_valid_o,
  output logic signed [MOVE_W-1:0]     move_x_o,
  output logic signed [MOVE_W-1:0]     move_y_o,
  output logic                         click_left_o,
  output logic                         click_right_o,
  output logic                         scroll_valid_o,
  output logic signed [SCROLL_W-1:0]   scroll_amount_o,
  output logic                         in_tuning_mode_o,
  output logic [LEVEL_W-1:0]           gain_level_o
);

  // The gain covers every level that the level register can hold
  localparam int GAIN_W  = LEVEL_W + 1;
  localparam int LVL_MAX = (LEVELS > int'(LEVEL_RST)) ? LEVELS : int'(LEVEL_RST);
  localparam int MAG_W  = SAMPLE_W + 1;
  localparam int PW     = MAG_W + GAIN_W;
  localparam int MW     = PW + 1;
  localparam int YAW_SH = PW + $clog2(YAW_DIV);
  localparam int ACC_SH = PW + $clog2(ACCEL_DIV);
  localparam logic [MW-1:0] YAW_M = MW'(((64'd1 << YAW_SH) + YAW_DIV - 1) / YAW_DIV);
  localparam logic [MW-1:0] ACC_M = MW'(((64'd1 << ACC_SH) + ACCEL_DIV - 1) / ACCEL_DIV);
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Handshake: every stage moves when the result register is free or being emptied
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Configuration registers
  logic [DEB_W-1:0] deb_q;
  logic [DZ_W-1:0]  yaw_dz_q, acc_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= DEBOUNCE_RST;
      yaw_dz_q <= YAW_DZ_RST;
      acc_dz_q <= ACCEL_DZ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: deb_q    <= cfg_wdata_i[DEB_W-1:0];
        CFG_YAW_DZ:   yaw_dz_q <= cfg_wdata_i[DZ_W-1:0];
        CFG_ACCEL_DZ: acc_dz_q <= cfg_wdata_i[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input register
  logic                       s0_valid_q;
  logic                       s0_link_q;
  logic [TIME_W-1:0]          s0_now_q;
  logic [NUM_BTN-1:0]         s0_raw_q;
  logic signed [SAMPLE_W-1:0] s0_accel_q, s0_yaw_q;
  logic [STICK_W-1:0]         s0_stick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s0_link_q  <= link_up_i;
      s0_now_q   <= now_ms_i;
      s0_raw_q   <= {mode_level_i, enable_level_i, right_level_i, left_level_i};
      s0_accel_q <= accel_x_i;
      s0_yaw_q   <= yaw_step_i;
      s0_stick_q <= stick_y_i;
    end
  end

  // ---------------------------------------------------------------- stage 1: state
  logic [TIME_W-1:0]  change_time_q [NUM_BTN];
  logic [TIME_W-1:0]  change_time_d [NUM_BTN];
  logic [NUM_BTN-1:0] last_raw_q, stable_q, stable_d, changed;
  logic               tuning_q, tuning_d;
  logic [LEVEL_W-1:0] level_q, level_d, level_step;
  logic signed [SAMPLE_W-1:0] prev_accel_q, prev_accel_d;
  logic               first_q, first_d;
  logic               lpress, rpress, normal;
  logic signed [SAMPLE_W-1:0] dacc;
  logic [MAG_W-1:0]   yaw_mag, acc_mag;
  logic [GAIN_W-1:0]  gain;
  tick_info_t         info1;
  logic               s1_fire;

  assign s1_fire = adv && s0_valid_q && s0_link_q;

  always_comb begin
    for (int b = 0; b < NUM_BTN; b++) begin
      change_time_d[b] = (s0_raw_q[b] != last_raw_q[b]) ? s0_now_q : change_time_q[b];
      changed[b]  = (TIME_W'(s0_now_q - change_time_d[b]) > TIME_W'(deb_q)) &&
                    (s0_raw_q[b] != stable_q[b]);
      stable_d[b] = changed[b] ? s0_raw_q[b] : stable_q[b];
    end
    lpress = changed[BTN_LEFT] && !s0_raw_q[BTN_LEFT];
    rpress = changed[BTN_RIGHT] && !s0_raw_q[BTN_RIGHT];
    tuning_d = tuning_q ^ (changed[BTN_MODE] && !s0_raw_q[BTN_MODE]);

    // Left steps down before right steps up when both are pressed on the same tick
    level_step = (lpress && level_q > LEVEL_W'(1)) ? level_q - LEVEL_W'(1) : level_q;
    if (rpress && level_step < LEVEL_W'(LEVELS)) begin
      level_step = level_step + LEVEL_W'(1);
    end
    level_d      = tuning_d ? level_step : level_q;
    normal       = !tuning_d && !first_q;
    first_d      = tuning_d ? first_q : 1'b0;
    prev_accel_d = tuning_d ? prev_accel_q : s0_accel_q;

    // Magnitudes in 17 bits so that the most negative sample keeps its size
    dacc    = s0_accel_q - prev_accel_q;
    yaw_mag = s0_yaw_q[SAMPLE_W-1] ? MAG_W'(0) - MAG_W'(s0_yaw_q) : MAG_W'(s0_yaw_q);
    acc_mag = dacc[SAMPLE_W-1] ? MAG_W'(0) - MAG_W'(dacc) : MAG_W'(dacc);
    if (yaw_mag < MAG_W'(yaw_dz_q)) begin
      yaw_mag = '0;
    end
    if (acc_mag < MAG_W'(acc_dz_q)) begin
      acc_mag = '0;
    end
    gain = GAIN_W'({level_q, 1'b0} - (LEVEL_W + 1)'(1));

    info1.normal   = s0_link_q && normal;
    info1.en_held  = !stable_d[BTN_ENABLE];
    info1.click_l  = lpress;
    info1.click_r  = rpress;
    info1.scroll   = scroll_of(s0_stick_q);
    info1.scroll_v = info1.scroll != '0;
    info1.tuning   = s0_link_q ? tuning_d : tuning_q;
    info1.level    = s0_link_q ? level_d : level_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BTN; b++) begin
        change_time_q[b] <= '0;
      end
      last_raw_q   <= '1;
      stable_q     <= '1;
      tuning_q     <= 1'b0;
      level_q      <= LEVEL_RST;
      prev_accel_q <= '0;
      first_q      <= 1'b1;
    end else if (s1_fire) begin
      for (int b = 0; b < NUM_BTN; b++) begin
        change_time_q[b] <= change_time_d[b];
      end
      last_raw_q   <= s0_raw_q;
      stable_q     <= stable_d;
      tuning_q     <= tuning_d;
      level_q      <= level_d;
      prev_accel_q <= prev_accel_d;
      first_q      <= first_d;
    end
  end

  logic             s1_valid_q;
  tick_info_t       s1_info_q;
  logic [PW-1:0]    s1_yaw_p_q, s1_acc_p_q;
  logic             s1_mx_neg_q, s1_my_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  // The move opposes the sign of the motion
  always_ff @(posedge clk_i) begin
    if (adv && s0_valid_q) begin
      s1_info_q   <= info1;
      s1_yaw_p_q  <= PW'(yaw_mag) * PW'(gain);
      s1_acc_p_q  <= PW'(acc_mag) * PW'(gain);
      s1_mx_neg_q <= !s0_yaw_q[SAMPLE_W-1];
      s1_my_neg_q <= !dacc[SAMPLE_W-1];
    end
  end

  // ---------------------------------------------------------------- stage 2: divide
  logic [PW+MW-1:0] yaw_prod, acc_prod;
  logic [PW-1:0]    yaw_quo, acc_quo;
  logic signed [SAMPLE_W-1:0] mx, my;

  always_comb begin
    yaw_prod = (PW + MW)'(s1_yaw_p_q) * (PW + MW)'(YAW_M);
    acc_prod = (PW + MW)'(s1_acc_p_q) * (PW + MW)'(ACC_M);
    yaw_quo  = PW'(yaw_prod >> YAW_SH);
    acc_quo  = PW'(acc_prod >> ACC_SH);
    if (s1_mx_neg_q) begin
      mx = (yaw_quo > PW'(S_MAX) + PW'(1)) ? S_MIN : SAMPLE_W'(PW'(0) - yaw_quo);
    end else begin
      mx = (yaw_quo > PW'(S_MAX)) ? S_MAX : SAMPLE_W'(yaw_quo);
    end
    if (s1_my_neg_q) begin
      my = (acc_quo > PW'(S_MAX) + PW'(1)) ? S_MIN : SAMPLE_W'(PW'(0) - acc_quo);
    end else begin
      my = (acc_quo > PW'(S_MAX)) ? S_MAX : SAMPLE_W'(acc_quo);
    end
  end

  logic                       s2_valid_q;
  tick_info_t                 s2_info_q;
  logic signed [SAMPLE_W-1:0] s2_mx_q, s2_my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      s2_info_q <= s1_info_q;
      s2_mx_q   <= mx;
      s2_my_q   <= my;
    end
  end

  // ---------------------------------------------------------------- stage 3: filter
  logic signed [FILT_W-1:0]   filt_x_q, filt_y_q, filt_x_d, filt_y_d;
  logic signed [FILT_W+7:0]   fy_keep, fy_in;
  logic signed [FILT_W-1:0]   cx, cy;
  logic signed [MOVE_W-1:0]   ox, oy;
  logic                       mv;

  function automatic logic signed [MOVE_W-1:0] cursor_of(input logic signed [FILT_W-1:0] f);
    logic signed [FILT_W-1:0] t;
    // Division by 256 rounding toward zero
    t = f[FILT_W-1] ? ((f + FILT_W'(255)) >>> Q_SH) : (f >>> Q_SH);
    if (t > FILT_W'(MOVE_LIM)) begin
      return MOVE_W'(MOVE_LIM);
    end
    if (t < -FILT_W'(MOVE_LIM)) begin
      return -MOVE_W'(MOVE_LIM);
    end
    return MOVE_W'(t);
  endfunction

  always_comb begin
    fy_keep  = (FILT_W + 8)'(filt_y_q) * (FILT_W + 8)'(FILT_Y_KEEP);
    fy_in    = (FILT_W + 8)'(s2_my_q) * (FILT_W + 8)'(FILT_Y_IN);
    filt_x_d = (FILT_W'(s2_mx_q) <<< FILT_X_IN_SH) + (filt_x_q >>> FILT_X_KEEP_SH);
    filt_y_d = FILT_W'(fy_in) + FILT_W'(fy_keep >>> Q_SH);
    cx = filt_x_d;
    cy = filt_y_d;
    ox = cursor_of(cx);
    oy = cursor_of(cy);
    mv = s2_info_q.normal && s2_info_q.en_held && (ox != '0 || oy != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_x_q <= '0;
      filt_y_q <= '0;
    end else if (adv && s2_valid_q && s2_info_q.normal) begin
      filt_x_q <= filt_x_d;
      filt_y_q <= filt_y_d;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      move_valid_o     <= mv;
      move_x_o         <= mv ? ox : '0;
      move_y_o         <= mv ? oy : '0;
      click_left_o     <= s2_info_q.normal && s2_info_q.click_l;
      click_right_o    <= s2_info_q.normal && s2_info_q.click_r;
      scroll_valid_o   <= s2_info_q.normal && s2_info_q.scroll_v;
      scroll_amount_o  <= s2_info_q.normal ? s2_info_q.scroll : '0;
      in_tuning_mode_o <= s2_info_q.tuning;
      gain_level_o     <= s2_info_q.level;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------- assertions
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q >= LEVEL_W'(1) && level_q <= LEVEL_W'(LVL_MAX))
    else $error("gain level left its range");

  a_no_move_in_tuning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && move_valid_o |-> !in_tuning_mode_o && (move_x_o != '0 || move_y_o != '0))
    else $error("move issued in tuning mode or with zero motion");

  a_idle_scroll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !scroll_valid_o |-> scroll_amount_o == '0)
    else $error("scroll amount set without a scroll beat");

  a_move_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> move_x_o != {1'b1, {(MOVE_W-1){1'b0}}} &&
                    move_y_o != {1'b1, {(MOVE_W-1){1'b0}}})
    else $error("cursor move outside the clamp");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the result beat is stalled");

endmodule

// ----- verif/air_mouse_motion_conditioner_top_tb.sv -----
// Self-checking testbench for the air mouse motion conditioner with its own tick predictor.
`timescale 1ns / 100ps

module air_mouse_motion_conditioner_top_tb;
  import ammc_pkg::*;

  typedef struct packed {
    logic                       link_up;
    logic [TIME_W-1:0]          now_ms;
    logic                       left;
    logic                       right;
    logic                       enable;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] yaw_step;
    logic [STICK_W-1:0]         stick_y;
  } tick_t;

  typedef struct packed {
    logic                       move_valid;
    logic signed [MOVE_W-1:0]   move_x;
    logic signed [MOVE_W-1:0]   move_y;
    logic                       click_left;
    logic                       click_right;
    logic                       scroll_valid;
    logic signed [SCROLL_W-1:0] scroll_amount;
    logic                       tuning;
    logic [LEVEL_W-1:0]         level;
  } report_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic link_up_i;
  logic [TIME_W-1:0] now_ms_i;
  logic left_level_i;
  logic right_level_i;
  logic enable_level_i;
  logic mode_level_i;
  logic signed [SAMPLE_W-1:0] accel_x_i;
  logic signed [SAMPLE_W-1:0] yaw_step_i;
  logic [STICK_W-1:0] stick_y_i;
  logic out_valid_o;
  logic out_ready_i;
  logic move_valid_o;
  logic signed [MOVE_W-1:0] move_x_o;
  logic signed [MOVE_W-1:0] move_y_o;
  logic click_left_o;
  logic click_right_o;
  logic scroll_valid_o;
  logic signed [SCROLL_W-1:0] scroll_amount_o;
  logic in_tuning_mode_o;
  logic [LEVEL_W-1:0] gain_level_o;

  air_mouse_motion_conditioner_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .link_up_i       (link_up_i),
    .now_ms_i        (now_ms_i),
    .left_level_i    (left_level_i),
    .right_level_i   (right_level_i),
    .enable_level_i  (enable_level_i),
    .mode_level_i    (mode_level_i),
    .accel_x_i       (accel_x_i),
    .yaw_step_i      (yaw_step_i),
    .stick_y_i       (stick_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .move_valid_o    (move_valid_o),
    .move_x_o        (move_x_o),
    .move_y_o        (move_y_o),
    .click_left_o    (click_left_o),
    .click_right_o   (click_right_o),
    .scroll_valid_o  (scroll_valid_o),
    .scroll_amount_o (scroll_amount_o),
    .in_tuning_mode_o(in_tuning_mode_o),
    .gain_level_o    (gain_level_o)
  );

  // Register copies and predictor state
  logic [DEB_W-1:0]           cfg_debounce = DEBOUNCE_RST;
  logic [DZ_W-1:0]            cfg_yaw_dz   = YAW_DZ_RST;
  logic [DZ_W-1:0]            cfg_accel_dz = ACCEL_DZ_RST;
  logic [TIME_W-1:0]          btn_change_t [NUM_BTN] = '{default: '0};
  logic                       btn_last     [NUM_BTN] = '{default: 1'b1};
  logic                       btn_stable   [NUM_BTN] = '{default: 1'b1};
  logic                       tuning_on      = 1'b0;
  logic [LEVEL_W-1:0]         gain_lvl       = LEVEL_RST;
  logic signed [SAMPLE_W-1:0] prev_accel     = '0;
  logic                       awaiting_first = 1'b1;
  int                         lpf_x          = 0;
  int                         lpf_y          = 0;

  report_t expected_reports[$];
  report_t want_report;
  int      errors;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_off_req;
  int      hold_off_left;

  // Random sequence generator state
  logic [TIME_W-1:0]          gen_now;
  logic                       gen_btn [NUM_BTN];
  logic signed [SAMPLE_W-1:0] gen_ax;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("air_mouse_motion_conditioner_top_tb NOT OK");
    $finish;
  end

  function automatic bit debounce_btn(int b, logic raw, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] held;
    if (raw != btn_last[b]) begin
      btn_change_t[b] = now;
      btn_last[b] = raw;
    end
    held = now - btn_change_t[b];
    if (held > TIME_W'(cfg_debounce) && raw != btn_stable[b]) begin
      btn_stable[b] = raw;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int clamp_move(int v);
    if (v > MOVE_LIM) return MOVE_LIM;
    if (v < -MOVE_LIM) return -MOVE_LIM;
    return v;
  endfunction

  // Advances the predicted state by one tick and returns the report it should produce.
  function automatic report_t condition_tick(tick_t t);
    report_t r;
    bit lch, rch, mch, lpress, rpress;
    int dacc, yaw, gain, mx, my, ox, oy, sc;
    logic [SAMPLE_W-1:0] d16;
    r = '0;
    if (t.link_up) begin
      lch = debounce_btn(BTN_LEFT, t.left, t.now_ms);
      rch = debounce_btn(BTN_RIGHT, t.right, t.now_ms);
      void'(debounce_btn(BTN_ENABLE, t.enable, t.now_ms));
      mch = debounce_btn(BTN_MODE, t.mode, t.now_ms);
      lpress = lch && !btn_stable[BTN_LEFT];
      rpress = rch && !btn_stable[BTN_RIGHT];
      if (mch && !btn_stable[BTN_MODE]) tuning_on = !tuning_on;
      if (tuning_on) begin
        if (lpress && gain_lvl > 1) gain_lvl = gain_lvl - 1'b1;
        if (rpress && int'(gain_lvl) < LEVELS_DEF) gain_lvl = gain_lvl + 1'b1;
      end else if (awaiting_first) begin
        prev_accel = t.accel_x;
        awaiting_first = 1'b0;
      end else begin
        d16 = t.accel_x - prev_accel;
        dacc = int'($signed(d16));
        yaw = int'(t.yaw_step);
        gain = 2 * int'(gain_lvl) - 1;
        if ((yaw < 0 ? -yaw : yaw) < int'(cfg_yaw_dz)) yaw = 0;
        if ((dacc < 0 ? -dacc : dacc) < int'(cfg_accel_dz)) dacc = 0;
        mx = -(yaw * gain) / YAW_DIV;
        if (mx > 32767) mx = 32767;
        if (mx < -32768) mx = -32768;
        my = -(dacc * gain) / ACCEL_DIV;
        // Arithmetic shifts give the floor of the retained part.
        lpf_x = mx * 128 + int'((longint'(lpf_x) * 128) >>> Q_SH);
        lpf_y = my * FILT_Y_IN + int'((longint'(lpf_y) * FILT_Y_KEEP) >>> Q_SH);
        ox = clamp_move(lpf_x / 256);
        oy = clamp_move(lpf_y / 256);
        if (!btn_stable[BTN_ENABLE] && (ox != 0 || oy != 0)) begin
          r.move_valid = 1'b1;
          r.move_x = MOVE_W'(ox);
          r.move_y = MOVE_W'(oy);
        end
        r.click_left = lpress;
        r.click_right = rpress;
        if (int'(t.stick_y) < SCROLL_LOW) begin
          sc = SCROLL_STEPS - int'(t.stick_y) * SCROLL_STEPS / SCROLL_LOW;
        end else if (int'(t.stick_y) > SCROLL_HIGH) begin
          sc = -((int'(t.stick_y) - SCROLL_HIGH) * SCROLL_STEPS / (STICK_MAX - SCROLL_HIGH));
        end else begin
          sc = 0;
        end
        if (sc > 1 || sc < -1) begin
          r.scroll_valid = 1'b1;
          r.scroll_amount = SCROLL_W'(sc);
        end
        prev_accel = t.accel_x;
      end
    end
    r.tuning = tuning_on;
    r.level = gain_lvl;
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_off_req > 0) begin
      hold_off_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: report beat with none expected, expected none, actual move %0d/%0d",
                 $time, move_x_o, move_y_o);
        errors++;
      end else begin
        want_report = expected_reports.pop_front();
        check_field("move_valid", int'(want_report.move_valid), int'(move_valid_o));
        check_field("move_x", int'(want_report.move_x), int'(move_x_o));
        check_field("move_y", int'(want_report.move_y), int'(move_y_o));
        check_field("click_left", int'(want_report.click_left), int'(click_left_o));
        check_field("click_right", int'(want_report.click_right), int'(click_right_o));
        check_field("scroll_valid", int'(want_report.scroll_valid), int'(scroll_valid_o));
        check_field("scroll_amount", int'(want_report.scroll_amount),
                    int'(scroll_amount_o));
        check_field("in_tuning_mode", int'(want_report.tuning), int'(in_tuning_mode_o));
        check_field("gain_level", int'(want_report.level), int'(gain_level_o));
      end
    end
  end

  // Offers one tick, holding it until the beat is taken, then records its prediction.
  task automatic send_tick(input tick_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    link_up_i      <= t.link_up;
    now_ms_i       <= t.now_ms;
    left_level_i   <= t.left;
    right_level_i  <= t.right;
    enable_level_i <= t.enable;
    mode_level_i   <= t.mode;
    accel_x_i      <= t.accel_x;
    yaw_step_i     <= t.yaw_step;
    stick_y_i      <= t.stick_y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_reports.push_back(condition_tick(t));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: cfg_debounce = data[DEB_W-1:0];
      CFG_YAW_DZ:   cfg_yaw_dz = data[DZ_W-1:0];
      CFG_ACCEL_DZ: cfg_accel_dz = data[DZ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int deb, input int yaw_dz, input int acc_dz);
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
    write_reg(CFG_YAW_DZ, CFG_DATA_W'(yaw_dz));
    write_reg(CFG_ACCEL_DZ, CFG_DATA_W'(acc_dz));
  endtask

  task automatic set_idling(input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
  endtask

  function automatic tick_t tick_of(int lk, logic [TIME_W-1:0] now, int l, int r,
                                    int e, int m, int ax, int yaw, int stick);
    tick_t t;
    t.link_up = lk[0];
    t.now_ms = now;
    t.left = l[0];
    t.right = r[0];
    t.enable = e[0];
    t.mode = m[0];
    t.accel_x = SAMPLE_W'(ax);
    t.yaw_step = SAMPLE_W'(yaw);
    t.stick_y = STICK_W'(stick);
    return t;
  endfunction

  // Buttons are active low; levels only count once stable for longer than the debounce time.
  task automatic test_directed();
    send_tick(tick_of(0, 5000, 0, 0, 0, 0, 1234, 500, 0));          // link down, no effect
    send_tick(tick_of(1, 100, 1, 1, 1, 1, 32767, 0, 2048));         // first sample only
    send_tick(tick_of(1, 101, 1, 1, 0, 1, -32768, -32768, 0));      // delta wraps, yaw saturates
    send_tick(tick_of(1, 112, 1, 1, 0, 1, 0, 32767, 4095));         // enable held, delta -32768
    send_tick(tick_of(1, 113, 1, 1, 0, 1, 599, 29, 1830));          // just inside dead zones
    send_tick(tick_of(1, 114, 1, 1, 0, 1, 1199, 30, 1850));         // on the dead-zone edges
    send_tick(tick_of(1, 115, 1, 1, 0, 1, 599, -30, 1851));
    send_tick(tick_of(1, 116, 0, 1, 0, 1, 1199, 0, 1829));
    send_tick(tick_of(1, 127, 0, 0, 0, 1, 1199, 77, 1097));         // left click
    send_tick(tick_of(1, 138, 1, 0, 0, 1, 5000, -900, 3000));       // right click
    send_tick(tick_of(1, 149, 1, 1, 0, 0, -5000, 0, 2500));
    send_tick(tick_of(1, 160, 1, 1, 0, 0, 100, 300, 0));            // enter tuning mode
    send_tick(tick_of(1, 161, 1, 0, 0, 0, 20000, 3000, 0));
    send_tick(tick_of(1, 172, 1, 0, 0, 0, -20000, -3000, 4095));    // level up in tuning
    send_tick(tick_of(1, 32'hFFFF_FFF0, 1, 1, 0, 1, 0, 0, 0));
    send_tick(tick_of(1, 32'h0000_0005, 1, 1, 0, 1, 0, 0, 0));      // time wraps round
    send_tick(tick_of(1, 6, 1, 1, 0, 0, 300, 1000, 1000));
    send_tick(tick_of(1, 17, 1, 1, 0, 0, -32768, 1000, 1000));      // back to normal mode
    send_tick(tick_of(1, 18, 1, 1, 0, 1, 32767, -1000, 3500));
    send_tick(tick_of(1, 29, 1, 1, 1, 1, 0, 12345, 2000));
    send_tick(tick_of(1, 40, 1, 1, 1, 1, 0, 12345, 2000));          // enable released
    send_tick(tick_of(0, 32'hFFFF_FFFF, 0, 0, 0, 0, -1, -1, 4095));
    wait_drained();
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    int r;
    t.link_up = ($urandom_range(99) < 95);
    r = $urandom_range(99);
    if (r < 3) begin
      gen_now = $urandom();
    end else if (r >= 8) begin
      gen_now = gen_now + TIME_W'($urandom_range(1, int'(cfg_debounce) / 3 + 12));
    end
    if ($urandom_range(99) < 10) gen_btn[BTN_LEFT] = !gen_btn[BTN_LEFT];
    if ($urandom_range(99) < 10) gen_btn[BTN_RIGHT] = !gen_btn[BTN_RIGHT];
    if ($urandom_range(99) < 4) gen_btn[BTN_ENABLE] = !gen_btn[BTN_ENABLE];
    if ($urandom_range(99) < 3) gen_btn[BTN_MODE] = !gen_btn[BTN_MODE];
    if ($urandom_range(99) < 10) begin
      gen_ax = SAMPLE_W'($urandom());
    end else begin
      gen_ax = gen_ax + SAMPLE_W'(int'($urandom_range(0, 6000)) - 3000);
    end
    t.now_ms = gen_now;
    t.left = gen_btn[BTN_LEFT];
    t.right = gen_btn[BTN_RIGHT];
    t.enable = gen_btn[BTN_ENABLE];
    t.mode = gen_btn[BTN_MODE];
    t.accel_x = gen_ax;
    if ($urandom_range(99) < 10) begin
      t.yaw_step = SAMPLE_W'($urandom());
    end else begin
      t.yaw_step = SAMPLE_W'(int'($urandom_range(0, 800)) - 400);
    end
    if ($urandom_range(99) < 15) begin
      t.stick_y = STICK_W'(SCROLL_LOW - 10 + $urandom_range(0, 40));
    end else begin
      t.stick_y = STICK_W'($urandom_range(0, STICK_MAX));
    end
    return t;
  endfunction

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) send_tick(random_tick());
    wait_drained();
  endtask

  // The receiver stops for a long stretch while ticks keep coming, so the pipeline fills.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_off_req = 150;
    for (int i = 0; i < 40; i++) send_tick(random_tick());
    wait_drained();
  endtask

  initial begin
    errors = 0;
    hold_off_req = 0;
    hold_off_left = 0;
    gen_now = 1000;
    gen_ax = '0;
    for (int b = 0; b < NUM_BTN; b++) gen_btn[b] = 1'b1;
    set_idling(17, 51);
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_DEBOUNCE;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    out_ready_i    <= 1'b0;
    link_up_i      <= 1'b0;
    now_ms_i       <= '0;
    left_level_i   <= 1'b1;
    right_level_i  <= 1'b1;
    enable_level_i <= 1'b1;
    mode_level_i   <= 1'b1;
    accel_x_i      <= '0;
    yaw_step_i     <= '0;
    stick_y_i      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_backpressure();

    set_idling(17, 51);
    apply_settings(0, 0, 0);
    test_random_traffic(400);

    set_idling(51, 17);
    apply_settings(255, 32767, 32767);
    test_random_traffic(300);

    set_idling(0, 0);
    apply_settings(int'(DEBOUNCE_RST), int'(YAW_DZ_RST), int'(ACCEL_DZ_RST));
    test_random_traffic(400);

    set_idling(17, 51);
    apply_settings($urandom_range(0, 40), $urandom_range(0, 2000), $urandom_range(0, 2000));
    test_random_traffic(400);

    set_idling(51, 17);
    apply_settings($urandom_range(0, 40), $urandom_range(0, 2000), $urandom_range(0, 2000));
    test_random_traffic(400);

    set_idling(0, 0);
    test_random_traffic(100);

    if (errors == 0) begin
      $display("air_mouse_motion_conditioner_top_tb OK");
    end else begin
      $display("air_mouse_motion_conditioner_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ammc_pkg.sv
rtl/air_mouse_motion_conditioner_top.sv
verif/air_mouse_motion_conditioner_top_tb.sv
